// ===== hw/rtl/life_pkg.sv =====
package life_pkg;

    localparam int COORD_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    localparam logic [S_TUSER_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [S_TUSER_W-1:0] MODE_READ  = 2'd1;
    localparam logic [S_TUSER_W-1:0] MODE_STEP  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_LOW   = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_DONE
    } t_state;

    function automatic logic life_rule(input logic alive, input logic [3:0] count);
        logic res;
        if (alive) begin
            res = (count == SURVIVE_LOW) || (count == BIRTH_COUNT);
        end else begin
            res = (count == BIRTH_COUNT);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/life_automaton_toroidal_grid.sv =====
// Cell read or write: the row is read, then modified and written back for a write;
// a request out of range or with an unused mode goes straight to the result.
// Generation step: the row memory is swept one row per cycle.
// One request in flight at a time: a new request is taken only in idle, once the last
// result has been registered; the next request is taken while the last result waits.
// Synchronous active-low reset returns to idle and clears the per-row valid bits,
// so every row reads as all dead until it is next written.
module life_automaton_toroidal_grid #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [life_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // col[7:0], row[15:8], cell_in[16]
    input  logic [life_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // mode[1:0]
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [life_pkg::M_TDATA_W-1:0] o_m_axis_tdata   // cell_out[0], in_range[1]
);
    import life_pkg::*;

    localparam int RAW = $clog2(GRID_HEIGHT);
    localparam int CW  = $clog2(GRID_HEIGHT + 3);

    localparam logic [COORD_W-1:0] WIDTH_C   = COORD_W'(GRID_WIDTH);
    localparam logic [COORD_W-1:0] HEIGHT_C  = COORD_W'(GRID_HEIGHT);
    localparam logic [RAW-1:0]     LAST_ROW  = RAW'(GRID_HEIGHT - 1);
    localparam logic [CW-1:0]      CNT_ROW0  = CW'(2);
    localparam logic [CW-1:0]      CNT_WR    = CW'(3);
    localparam logic [CW-1:0]      CNT_RDEND = CW'(GRID_HEIGHT);
    localparam logic [CW-1:0]      CNT_SHEND = CW'(GRID_HEIGHT + 1);
    localparam logic [CW-1:0]      CNT_FINAL = CW'(GRID_HEIGHT + 2);

    t_state r_state;
    t_state n_state;

    logic [S_TUSER_W-1:0] r_mode;
    logic [COORD_W-1:0]   r_col;
    logic [COORD_W-1:0]   r_row;
    logic                 r_cell_in;
    logic [CW-1:0]        r_cnt;

    logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_row_valid;
    logic [GRID_WIDTH-1:0] r_rd_data;
    logic                  r_rd_ok;

    logic [GRID_WIDTH-1:0] r_above;
    logic [GRID_WIDTH-1:0] r_cur;
    logic [GRID_WIDTH-1:0] r_first;

    logic r_res_cell;
    logic r_res_range;
    logic r_out_valid;
    logic r_out_cell;
    logic r_out_range;

    logic [S_TUSER_W-1:0] in_mode;
    logic [COORD_W-1:0]   in_col;
    logic [COORD_W-1:0]   in_row;
    logic                 in_cell;
    logic                 in_inside;
    logic                 in_cell_op;
    logic                 s_acc;
    logic                 done_fire;

    logic                  mem_re;
    logic [RAW-1:0]        rd_addr;
    logic                  mem_we;
    logic [RAW-1:0]        wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;

    logic [GRID_WIDTH-1:0] rd_eff;
    logic [GRID_WIDTH-1:0] bit_mask;
    logic                  rd_bit;
    logic [GRID_WIDTH-1:0] below_row;
    logic [GRID_WIDTH-1:0] gen_row;

    assign in_mode    = i_s_axis_tuser;
    assign in_col     = i_s_axis_tdata[7:0];
    assign in_row     = i_s_axis_tdata[15:8];
    assign in_cell    = i_s_axis_tdata[16];
    assign in_inside  = (in_col < WIDTH_C) && (in_row < HEIGHT_C);
    assign in_cell_op = in_inside && ((in_mode == MODE_WRITE) || (in_mode == MODE_READ));

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign done_fire       = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign rd_eff    = r_rd_ok ? r_rd_data : '0;
    assign bit_mask  = GRID_WIDTH'(1) << r_col;
    assign rd_bit    = |(rd_eff & bit_mask);
    assign below_row = (r_cnt == CNT_FINAL) ? r_first : rd_eff;

    always_comb begin
        for (int c = 0; c < GRID_WIDTH; c++) begin
            int lf;
            int rt;
            logic [3:0] cnt;
            lf  = (c == 0) ? GRID_WIDTH - 1 : c - 1;
            rt  = (c == GRID_WIDTH - 1) ? 0 : c + 1;
            cnt = 4'(r_above[lf]) + 4'(r_above[c]) + 4'(r_above[rt])
                + 4'(r_cur[lf]) + 4'(r_cur[rt])
                + 4'(below_row[lf]) + 4'(below_row[c]) + 4'(below_row[rt]);
            gen_row[c] = life_rule(r_cur[c], cnt);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_mode == MODE_STEP) begin
                        n_state = ST_SWEEP;
                    end else if (in_cell_op) begin
                        n_state = ST_ACCESS;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ACCESS: begin
                n_state = ST_DONE;
            end
            ST_SWEEP: begin
                if (r_cnt == CNT_FINAL) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        mem_re  = 1'b0;
        rd_addr = '0;
        mem_we  = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && in_cell_op) begin
                    mem_re  = 1'b1;
                    rd_addr = in_row[RAW-1:0];
                end
            end
            ST_ACCESS: begin
                if (r_mode == MODE_WRITE) begin
                    mem_we  = 1'b1;
                    wr_addr = r_row[RAW-1:0];
                    wr_data = (rd_eff & ~bit_mask) | (r_cell_in ? bit_mask : '0);
                end
            end
            ST_SWEEP: begin
                if (r_cnt <= CNT_RDEND) begin
                    mem_re  = 1'b1;
                    rd_addr = (r_cnt == '0) ? LAST_ROW : RAW'(r_cnt - CW'(1));
                end
                if (r_cnt >= CNT_WR) begin
                    mem_we  = 1'b1;
                    wr_addr = RAW'(r_cnt - CNT_WR);
                    wr_data = gen_row;
                end
            end
            ST_DONE: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
            r_rd_ok   <= r_row_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (mem_we) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode      <= in_mode;
            r_col       <= in_col;
            r_row       <= in_row;
            r_cell_in   <= in_cell;
            r_res_cell  <= 1'b0;
            r_res_range <= in_cell_op || (in_mode == MODE_STEP);
        end
        if ((r_state == ST_ACCESS) && (r_mode == MODE_READ)) begin
            r_res_cell <= rd_bit;
        end
        if ((r_state == ST_SWEEP) && (r_cnt != '0) && (r_cnt <= CNT_SHEND)) begin
            r_above <= r_cur;
            r_cur   <= rd_eff;
        end
        if ((r_state == ST_SWEEP) && (r_cnt == CNT_ROW0)) begin
            r_first <= rd_eff;
        end
        if (done_fire) begin
            r_out_cell  <= r_res_cell;
            r_out_range <= r_res_range;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - 2){1'b0}}, r_out_range, r_out_cell};

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (wr_addr != rd_addr))
        else $error("row read and write collide");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != ST_IDLE))
        else $error("request accepted without leaving idle");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && (r_cnt == CNT_FINAL)) |=> ((r_state == ST_DONE) && r_res_range))
        else $error("generation step did not finish with an in-range result");

    a_write_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && (r_cnt == CNT_FINAL)) |-> (mem_we && (wr_addr == LAST_ROW)))
        else $error("sweep did not end on the last row");

endmodule

// ===== sim/tb_life_automaton_toroidal_grid.sv =====
`timescale 1ns / 100ps

module tb_life_automaton_toroidal_grid;
    import life_pkg::*;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 32;

    localparam logic [S_TUSER_W-1:0] MODE_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 533;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] col;
        logic [7:0] row;
        logic       cell_in;
        logic [1:0] phase;
    } t_request;

    typedef struct packed {
        logic cell_out;
        logic in_range;
    } t_cell_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // col[7:0], row[15:8], cell_in[16]
    logic [S_TUSER_W-1:0] i_s_axis_tuser  = '0;  // mode[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // cell_out[0], in_range[1]

    t_request     request_q[$];
    t_cell_result expected_cells[$];
    bit           life_cells[GRID_HEIGHT][GRID_WIDTH];

    t_request     taken_request;
    t_cell_result due_cell;
    logic [1:0]   fill_phase = 2'd0;
    logic [1:0]   rx_phase   = 2'd0;
    bit           req_taken  = 1'b0;
    bit           failed     = 1'b0;
    bit           hold_done  = 1'b0;
    int           hold_left  = 0;
    int           results_seen = 0;
    int           stall_cycles = 0;

    life_automaton_toroidal_grid #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int live_around(int c, int r);
        int up;
        int dn;
        int lf;
        int rt;
        up = (r + GRID_HEIGHT - 1) % GRID_HEIGHT;
        dn = (r + 1) % GRID_HEIGHT;
        lf = (c + GRID_WIDTH - 1) % GRID_WIDTH;
        rt = (c + 1) % GRID_WIDTH;
        return life_cells[up][lf] + life_cells[up][c] + life_cells[up][rt]
             + life_cells[r][lf] + life_cells[r][rt]
             + life_cells[dn][lf] + life_cells[dn][c] + life_cells[dn][rt];
    endfunction

    function automatic void next_generation();
        bit nxt[GRID_HEIGHT][GRID_WIDTH];
        int n;
        for (int r = 0; r < GRID_HEIGHT; r++) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
                n = live_around(c, r);
                if (life_cells[r][c]) begin
                    nxt[r][c] = (n == 2) || (n == 3);
                end else begin
                    nxt[r][c] = (n == 3);
                end
            end
        end
        life_cells = nxt;
    endfunction

    function automatic t_cell_result predict_cell(t_request rq);
        t_cell_result res;
        bit hit;
        res = '0;
        hit = (rq.col < GRID_WIDTH) && (rq.row < GRID_HEIGHT);
        case (rq.mode)
            MODE_WRITE: begin
                if (hit) begin
                    life_cells[rq.row][rq.col] = rq.cell_in;
                end
                res.in_range = hit;
            end
            MODE_READ: begin
                if (hit) begin
                    res.cell_out = life_cells[rq.row][rq.col];
                end
                res.in_range = hit;
            end
            MODE_STEP: begin
                next_generation();
                res.in_range = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int idle_pct(logic [1:0] phase, bit receiver);
        int pct;
        case (phase)
            2'd0:    pct = receiver ? 48 : 9;
            2'd1:    pct = receiver ? 9 : 48;
            default: pct = 0;
        endcase
        return pct;
    endfunction

    task automatic push_request(logic [1:0] mode, int col, int row, int cell_in);
        t_request rq;
        rq.mode    = mode;
        rq.col     = 8'(col);
        rq.row     = 8'(row);
        rq.cell_in = 1'(cell_in);
        rq.phase   = fill_phase;
        request_q.push_back(rq);
    endtask

    task automatic push_far(logic [1:0] mode, int cell_in);
        if ($urandom_range(0, 1) == 0) begin
            push_request(mode, $urandom_range(GRID_WIDTH, 255), $urandom_range(0, 255), cell_in);
        end else begin
            push_request(mode, $urandom_range(0, GRID_WIDTH - 1),
                         $urandom_range(GRID_HEIGHT, 255), cell_in);
        end
    endtask

    task automatic seed_patch();
        int bc;
        int br;
        int n;
        int steps;
        int reads;
        bc = $urandom_range(0, GRID_WIDTH - 1);
        br = $urandom_range(0, GRID_HEIGHT - 1);
        n  = $urandom_range(6, 30);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                push_far(MODE_WRITE, $urandom_range(0, 1));
            end else begin
                push_request(MODE_WRITE, (bc + $urandom_range(0, 5)) % GRID_WIDTH,
                             (br + $urandom_range(0, 5)) % GRID_HEIGHT,
                             int'($urandom_range(0, 99) < 55));
            end
        end
        steps = $urandom_range(1, 4);
        for (int s = 0; s < steps; s++) begin
            push_request(MODE_STEP, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1));
            reads = $urandom_range(2, 8);
            for (int k = 0; k < reads; k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    push_far(MODE_READ, $urandom_range(0, 1));
                end else begin
                    push_request(MODE_READ,
                                 (bc + GRID_WIDTH - 1 + $urandom_range(0, 7)) % GRID_WIDTH,
                                 (br + GRID_HEIGHT - 1 + $urandom_range(0, 7)) % GRID_HEIGHT,
                                 $urandom_range(0, 1));
                end
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            push_request(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            taken_request = request_q.pop_front();
            rx_phase      = taken_request.phase;
            expected_cells.push_back(predict_cell(taken_request));
            req_taken     = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || req_taken)) begin
            req_taken = 1'b0;
            if (request_q.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(request_q[0].phase, 1'b0)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {7'd0, request_q[0].cell_in, request_q[0].row,
                                    request_q[0].col};
                i_s_axis_tuser  <= request_q[0].mode;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_cells.size() == 0) begin
                $error("result with no request outstanding: tdata 0x%h", o_m_axis_tdata);
                failed = 1'b1;
            end else begin
                due_cell = expected_cells.pop_front();
                if (o_m_axis_tdata[0] !== due_cell.cell_out) begin
                    $error("cell_out mismatch: expected %0d, actual %0d",
                           due_cell.cell_out, o_m_axis_tdata[0]);
                    failed = 1'b1;
                end
                if (o_m_axis_tdata[1] !== due_cell.in_range) begin
                    $error("in_range mismatch: expected %0d, actual %0d",
                           due_cell.in_range, o_m_axis_tdata[1]);
                    failed = 1'b1;
                end
            end
        end
    end

    // hold off once for a long stretch so the input side backs up
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= idle_pct(rx_phase, 1'b1));
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        push_request(MODE_WRITE, 0, 0, 1);
        push_request(MODE_WRITE, GRID_WIDTH - 1, 0, 1);
        push_request(MODE_WRITE, 0, GRID_HEIGHT - 1, 1);
        push_request(MODE_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1);
        push_request(MODE_READ, 0, 0, 1);
        push_request(MODE_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 0);
        push_request(MODE_WRITE, GRID_WIDTH, 0, 1);
        push_request(MODE_WRITE, 0, GRID_HEIGHT, 1);
        push_request(MODE_WRITE, 255, 255, 1);
        push_request(MODE_READ, GRID_WIDTH, 0, 0);
        push_request(MODE_READ, 255, 255, 1);
        push_request(MODE_READ, 1, 1, 0);
        push_request(MODE_UNUSED, 255, 255, 1);
        push_request(MODE_UNUSED, 0, 0, 0);
        push_request(MODE_STEP, 255, 255, 1);
        push_request(MODE_READ, 0, 0, 0);
        push_request(MODE_READ, GRID_WIDTH - 1, 0, 0);
        push_request(MODE_READ, 0, GRID_HEIGHT - 1, 0);
        push_request(MODE_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 0);
        push_request(MODE_WRITE, 0, 0, 0);
        push_request(MODE_STEP, 0, 0, 0);
        push_request(MODE_READ, 0, 0, 0);
        push_request(MODE_READ, GRID_WIDTH - 1, 0, 0);

        for (int p = 0; p < 3; p++) begin
            fill_phase = 2'(p);
            while (request_q.size() < (p + 1) * PHASE_ITEMS + 23) begin
                seed_patch();
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || expected_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (GRID_HEIGHT + 8) @(posedge i_clk);

        if (!failed && expected_cells.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/life_pkg.sv
hw/rtl/life_automaton_toroidal_grid.sv
sim/tb_life_automaton_toroidal_grid.sv
